/* sv/sis_pkg.sv */
// Package for the sorted index set unit: operation and status codes,
// the control state encoding and the control bundle driven to the cell row.
// No dependencies.
package sis_pkg;

  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int POSITION_W = 6;
  localparam int COUNT_W    = 7;

  localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_REMOVED = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

/* sv/sis_cell.sv */
// One slot of the sorted store: holds an entry, compares it with the
// broadcast value and shifts up or down with its neighbours.
// Depends on sis_pkg.
module sis_cell import sis_pkg::*; #(
  parameter int VW    = 32,
  parameter int CW    = 7,
  parameter int IW    = 6,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctrl_t    ctrl,
  input  logic [VW-1:0] value,
  input  logic [CW-1:0] count,
  input  logic [VW-1:0] left_entry,
  input  logic          left_lt,
  input  logic [VW-1:0] right_entry,
  output logic [VW-1:0] entry,
  output logic          lt,
  output logic          eq,
  output logic [IW-1:0] sel_index
);

  logic occupied;

  assign occupied  = CW'(INDEX) < count;
  assign sel_index = (!lt && left_lt) ? IW'(INDEX) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.cmp) begin
      lt <= occupied && (entry < value);
      eq <= occupied && (entry == value);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      entry <= left_lt ? value : left_entry;
    end else if (ctrl.del && !lt) begin
      entry <= right_entry;
    end
  end

endmodule

/* sv/sorted_index_set_unit.sv */
// Top level of the sorted index set: control sequencer, row of sis_cell
// slots, fill count and registered result. Depends on sis_pkg, sis_cell.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_stall  | func, index_value
//   out     | out_valid / out_stall| status, position, set_count
//
// An item passes three steps: accept, compare in every slot, then shift
// the row and load the result register; a new item is accepted only
// after the update step, which waits while the result is stalled.
// Synchronous reset empties the set; the store contents are not cleared.
// A stalled result lets one more item in, then holds it in the update
// step and stalls the input until the result leaves.
module sorted_index_set_unit import sis_pkg::*; #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     func,
  input  logic [31:0]           index_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [POSITION_W-1:0] position,
  output logic [COUNT_W-1:0]    set_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t              state, state_next;
  logic [FUNC_W-1:0]   func_r;
  logic [VALUE_WIDTH-1:0] value;
  logic [CW-1:0]       count, count_next;
  cell_ctrl_t          ctrl;

  logic [VALUE_WIDTH-1:0] entries [DEPTH];
  logic [DEPTH-1:0]       lts, eqs;
  logic [IW-1:0]          sel [DEPTH];

  logic                   found;
  logic [IW-1:0]          pos;
  logic                   out_free;
  logic                   upd;
  status_t                status_next;
  logic [IW-1:0]          pos_next;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign upd      = (state == S_UPD) && out_free;
  assign found    = |eqs;

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos = pos | sel[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sis_cell #(
      .VW   (VALUE_WIDTH),
      .CW   (CW),
      .IW   (IW),
      .INDEX(g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .value      (value),
      .count      (count),
      .left_entry ((g == 0) ? value : entries[(g == 0) ? 0 : g - 1]),
      .left_lt    ((g == 0) ? 1'b1 : lts[(g == 0) ? 0 : g - 1]),
      .right_entry(entries[(g == DEPTH - 1) ? g : g + 1]),
      .entry      (entries[g]),
      .lt         (lts[g]),
      .eq         (eqs[g]),
      .sel_index  (sel[g])
    );
  end

  always_comb begin
    ctrl        = '0;
    ctrl.cmp    = (state == S_CMP);
    count_next  = count;
    status_next = ST_CLEARED;
    pos_next    = '0;
    if (func_r[1]) begin
      count_next = '0;
    end else if (func_r == FN_ADD) begin
      if (found) begin
        status_next = ST_PRESENT;
        pos_next    = pos;
      end else if (count == CW'(DEPTH)) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_ADDED;
        pos_next    = pos;
        ctrl.ins    = upd;
        count_next  = count + 1'b1;
      end
    end else begin
      if (found) begin
        status_next = ST_REMOVED;
        pos_next    = pos;
        ctrl.del    = upd;
        count_next  = count - 1'b1;
      end else begin
        status_next = ST_ABSENT;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      func_r <= func;
      value  <= VALUE_WIDTH'(index_value);
    end
    if (upd) begin
      status    <= status_next;
      position  <= POSITION_W'(pos_next);
      set_count <= COUNT_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the set");

  a_del_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctrl.del |=> count == $past(count) - 1'b1)
    else $error("remove did not shrink the set");

  a_upd_result: assert property (@(posedge clk) disable iff (rst)
    upd |=> out_valid)
    else $error("update step gave no result");

endmodule
